// ===== rtl/pkp_pkg.sv =====
`timescale 1ns / 1ps

package pkp_pkg;

	// Q16.32 coordinate word
	localparam int QW = 48;
	typedef logic signed [QW-1:0] q_t;

	localparam q_t ONE_Q       = 48'sd4294967296;
	localparam q_t MAX_Q       = 48'sh7FFF_FFFF_FFFF;
	localparam q_t MIN_Q       = 48'sh8000_0000_0000;
	localparam q_t COORD_LIMIT = 48'sd42949672960;
	localparam q_t SLOPE_LIMIT = 48'sd4294967296;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_KICK,
		REG_ORDER,
		REG_PLANE,
		REG_COS,
		REG_SIN,
		REG_OFFX,
		REG_OFFY,
		REG_OFFZ
	} cfg_reg_t;

	// Magnitude of a signed word; the most negative value maps to 2^47
	function automatic logic [QW-1:0] mag_q(input q_t v);
		return v[QW-1] ? QW'(-v) : QW'(v);
	endfunction

	// Apply a sign to a magnitude and saturate to the signed word range
	function automatic q_t sign_sat(input logic [63:0] m, input logic neg);
		logic big;
		big = (m[63:QW-1] != '0);
		if (neg)
			return big ? MIN_Q : q_t'(-$signed({1'b0, m[QW-2:0]}));
		else
			return big ? MAX_Q : q_t'({1'b0, m[QW-2:0]});
	endfunction

endpackage

// ===== rtl/pkp_qmul.sv =====
`timescale 1ns / 1ps

module pkp_qmul import pkp_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q_t   a,
	input  q_t   b,
	output q_t   p
);

	logic [QW-1:0] ma_s1, mb_s1;
	logic          neg_s1, neg_s2, neg_s3;
	logic [47:0]   pll_s2, plh_s2, phl_s2, phh_s2;
	logic [63:0]   m_s3;
	q_t            p_s4;
	logic [95:0]   prod_sum;

	// Sum partial products and add half an LSB of the result for rounding
	always_comb begin
		prod_sum = 96'(pll_s2)
			+ ((96'(plh_s2) + 96'(phl_s2)) << 24)
			+ (96'(phh_s2) << 48)
			+ (96'(1) << 31);
	end

	// Four-stage signed product: magnitudes, partials, sum, sign and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= mag_q(a);
			mb_s1  <= mag_q(b);
			neg_s1 <= a[QW-1] ^ b[QW-1];
			pll_s2 <= ma_s1[23:0] * mb_s1[23:0];
			plh_s2 <= ma_s1[23:0] * mb_s1[47:24];
			phl_s2 <= ma_s1[47:24] * mb_s1[23:0];
			phh_s2 <= ma_s1[47:24] * mb_s1[47:24];
			neg_s2 <= neg_s1;
			m_s3   <= prod_sum[95:32];
			neg_s3 <= neg_s2;
			p_s4   <= sign_sat(m_s3, neg_s3);
		end
	end

	assign p = p_s4;

endmodule

// ===== rtl/polynomial_kick_particle_top.sv =====
`timescale 1ns / 1ps

// Polynomial kick on a stream of particles in signed Q16.32. The block takes one
// particle per clock while the output is not stalled and returns it in order;
// the path runs through a chain of product units (frame shift, rotation, up to
// fifteen power steps, kick, back rotation, exit shift), two 41-step square
// root sections for the path-length term, and a 47-step divider for the
// momentum scaling, which runs beside the rotation. The whole pipeline holds
// while a result waits at the output, so input waits during a stall and
// nothing is lost. Configuration writes are taken in every cycle and must
// only happen with the pipeline empty.
module polynomial_kick_particle_top import pkp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_addr,
	input  logic [47:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// x_pos, x_slope, y_pos, y_slope, path_s, mom_dev (48 bits each)
	input  logic [287:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// x_out, xp_out, y_out, yp_out, s_out, delta_out (48 bits each)
	output logic [287:0] m_axis_tdata,
	// lost
	output logic [0:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int QL        = 4;
	localparam int POW_STEPS = 15;
	localparam int SQ_STEPS  = 41;
	localparam int DV_STEPS  = 47;

	localparam int K_IN     = 0;
	localparam int K_ROT    = K_IN + QL + 1;
	localparam int K_POW    = K_ROT + QL + 1;
	localparam int K_KICK   = K_POW + QL * POW_STEPS;
	localparam int K_BACK   = K_KICK + QL + 1;
	localparam int K_OUT    = K_BACK + QL + 1;
	localparam int SQ1_INIT = K_ROT;
	localparam int K_PT1    = SQ1_INIT + SQ_STEPS;
	localparam int K_S1     = K_PT1 + QL + 1;
	localparam int SQ2_INIT = K_OUT + QL + 1;
	localparam int K_PT2    = SQ2_INIT + SQ_STEPS;
	localparam int K_FIN    = K_PT2 + QL + 1;
	localparam int NST      = K_FIN + 1;
	localparam int DV_INIT  = K_IN + 1;
	localparam int DV_LAST  = DV_INIT + DV_STEPS;
	localparam int DV_FIN   = DV_LAST + 1;

	// Product unit assignment
	localparam int M_SQX0 = 0;
	localparam int M_SQY0 = 1;
	localparam int M_DZX  = 2;
	localparam int M_DZY  = 3;
	localparam int M_CXP  = 4;
	localparam int M_SYP  = 5;
	localparam int M_CYP  = 6;
	localparam int M_SXP  = 7;
	localparam int M_CX1  = 8;
	localparam int M_SY1  = 9;
	localparam int M_CY1  = 10;
	localparam int M_SX1  = 11;
	localparam int M_DZP1 = 12;
	localparam int M_POW0 = 13;
	localparam int M_KICK = M_POW0 + POW_STEPS;
	localparam int M_BCX  = M_KICK + 1;
	localparam int M_BSY  = M_KICK + 2;
	localparam int M_BSX  = M_KICK + 3;
	localparam int M_BCY  = M_KICK + 4;
	localparam int M_DXO  = M_KICK + 5;
	localparam int M_DYO  = M_KICK + 6;
	localparam int M_SQX1 = M_KICK + 7;
	localparam int M_SQY1 = M_KICK + 8;
	localparam int M_DZP2 = M_KICK + 9;
	localparam int NMUL   = M_DZP2 + 1;

	typedef struct packed {
		q_t          x;
		q_t          xp;
		q_t          y;
		q_t          yp;
		q_t          s;
		q_t          d;
		logic        last;
		q_t          x1;
		q_t          y1;
		q_t          s1;
		q_t          xr;
		q_t          yr;
		q_t          xpr;
		q_t          ypr;
		q_t          pb;
		q_t          pw;
		q_t          kl;
		q_t          xo;
		q_t          xpo;
		q_t          yo;
		q_t          ypo;
		q_t          so;
		logic        lost;
		logic [81:0] sq_n;
		logic [45:0] sq_rem;
		logic [40:0] sq_root;
		logic [46:0] dv_bits;
		logic [47:0] dv_rem;
		logic [47:0] dv_ud;
		logic [46:0] dv_q;
		logic        dv_neg;
		logic        dv_over;
		logic        dv_zero;
	} item_t;

	q_t                kick_q, offx_q, offy_q, offz_q;
	logic [3:0]        order_q;
	logic              plane_q;
	logic signed [33:0] cos_q, sin_q;
	q_t                cos_w, sin_w;

	logic              en;
	logic [NST-1:0]    vld_s;
	item_t             cr_s [NST];
	item_t             nx   [NST];
	q_t                ma   [NMUL];
	q_t                mb   [NMUL];
	q_t                mres [NMUL];
	q_t                pwv  [POW_STEPS+1];

	function automatic logic signed [49:0] ext(input q_t v);
		return {{2{v[QW-1]}}, v};
	endfunction

	function automatic q_t sat_q(input logic signed [49:0] v);
		if (v > ext(MAX_Q))
			return MAX_Q;
		else if (v < ext(MIN_Q))
			return MIN_Q;
		else
			return v[QW-1:0];
	endfunction

	// Load the radicand (1 + a + b) scaled by 2^32
	function automatic item_t sq_init(input item_t t, input q_t sa, input q_t sb);
		logic [48:0] sum;
		sum = 49'(ONE_Q) + 49'(sa) + 49'(sb);
		t.sq_n    = {1'b0, sum, 32'b0};
		t.sq_rem  = '0;
		t.sq_root = '0;
		return t;
	endfunction

	// One digit of the restoring square root
	function automatic item_t sq_step(input item_t t);
		logic [45:0] remw;
		logic [42:0] trial;
		remw  = {t.sq_rem[43:0], t.sq_n[81:80]};
		trial = {t.sq_root, 2'b01};
		t.sq_n = {t.sq_n[79:0], 2'b00};
		if (remw >= 46'(trial)) begin
			t.sq_rem  = remw - 46'(trial);
			t.sq_root = {t.sq_root[39:0], 1'b1};
		end else begin
			t.sq_rem  = remw;
			t.sq_root = {t.sq_root[39:0], 1'b0};
		end
		return t;
	endfunction

	// One quotient bit of the restoring divider
	function automatic item_t dv_step(input item_t t);
		logic [48:0] remw;
		remw = {t.dv_rem, t.dv_bits[46]};
		t.dv_bits = {t.dv_bits[45:0], 1'b0};
		if (remw >= {1'b0, t.dv_ud}) begin
			t.dv_rem = 48'(remw - {1'b0, t.dv_ud});
			t.dv_q   = {t.dv_q[45:0], 1'b1};
		end else begin
			t.dv_rem = remw[47:0];
			t.dv_q   = {t.dv_q[45:0], 1'b0};
		end
		return t;
	endfunction

	assign cos_w = {{(QW-34){cos_q[33]}}, cos_q};
	assign sin_w = {{(QW-34){sin_q[33]}}, sin_q};

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_q  <= '0;
			order_q <= '0;
			plane_q <= 1'b0;
			cos_q   <= 34'sd4294967296;
			sin_q   <= '0;
			offx_q  <= '0;
			offy_q  <= '0;
			offz_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_KICK:  kick_q  <= cfg_data[47:0];
				REG_ORDER: order_q <= cfg_data[3:0];
				REG_PLANE: plane_q <= cfg_data[0];
				REG_COS:   cos_q   <= cfg_data[33:0];
				REG_SIN:   sin_q   <= cfg_data[33:0];
				REG_OFFX:  offx_q  <= cfg_data[47:0];
				REG_OFFY:  offy_q  <= cfg_data[47:0];
				REG_OFFZ:  offz_q  <= cfg_data[47:0];
			endcase
		end
	end

	// Product operands, each taken at the stage where its inputs are ready
	assign ma[M_SQX0] = cr_s[K_IN].xp;   assign mb[M_SQX0] = cr_s[K_IN].xp;
	assign ma[M_SQY0] = cr_s[K_IN].yp;   assign mb[M_SQY0] = cr_s[K_IN].yp;
	assign ma[M_DZX]  = offz_q;          assign mb[M_DZX]  = cr_s[K_IN].xp;
	assign ma[M_DZY]  = offz_q;          assign mb[M_DZY]  = cr_s[K_IN].yp;
	assign ma[M_CXP]  = cos_w;           assign mb[M_CXP]  = cr_s[K_IN].xp;
	assign ma[M_SYP]  = sin_w;           assign mb[M_SYP]  = cr_s[K_IN].yp;
	assign ma[M_CYP]  = cos_w;           assign mb[M_CYP]  = cr_s[K_IN].yp;
	assign ma[M_SXP]  = sin_w;           assign mb[M_SXP]  = cr_s[K_IN].xp;
	assign ma[M_CX1]  = cos_w;           assign mb[M_CX1]  = cr_s[K_ROT].x1;
	assign ma[M_SY1]  = sin_w;           assign mb[M_SY1]  = cr_s[K_ROT].y1;
	assign ma[M_CY1]  = cos_w;           assign mb[M_CY1]  = cr_s[K_ROT].y1;
	assign ma[M_SX1]  = sin_w;           assign mb[M_SX1]  = cr_s[K_ROT].x1;
	assign ma[M_DZP1] = offz_q;
	assign mb[M_DZP1] = q_t'({1'b0, cr_s[K_PT1].sq_root});
	assign ma[M_KICK] = cr_s[K_KICK].kl; assign mb[M_KICK] = pwv[POW_STEPS];
	assign ma[M_BCX]  = cos_w;           assign mb[M_BCX]  = cr_s[K_BACK].xpr;
	assign ma[M_BSY]  = sin_w;           assign mb[M_BSY]  = cr_s[K_BACK].ypr;
	assign ma[M_BSX]  = sin_w;           assign mb[M_BSX]  = cr_s[K_BACK].xpr;
	assign ma[M_BCY]  = cos_w;           assign mb[M_BCY]  = cr_s[K_BACK].ypr;
	assign ma[M_DXO]  = cr_s[K_OUT].xpo; assign mb[M_DXO]  = offz_q;
	assign ma[M_DYO]  = cr_s[K_OUT].ypo; assign mb[M_DYO]  = offz_q;
	assign ma[M_SQX1] = cr_s[K_OUT].xpo; assign mb[M_SQX1] = cr_s[K_OUT].xpo;
	assign ma[M_SQY1] = cr_s[K_OUT].ypo; assign mb[M_SQY1] = cr_s[K_OUT].ypo;
	assign ma[M_DZP2] = offz_q;
	assign mb[M_DZP2] = q_t'({1'b0, cr_s[K_PT2].sq_root});

	// Power chain: each step keeps its product only while below the order
	assign pwv[0] = cr_s[K_POW].pw;

	for (genvar i = 1; i <= POW_STEPS; i++) begin : g_pwv
		assign pwv[i] = (4'(i - 1) < order_q) ? mres[M_POW0 + i - 1]
			: cr_s[K_POW + QL * i].pw;
	end

	for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
		assign ma[M_POW0 + i] = pwv[i];
		assign mb[M_POW0 + i] = cr_s[K_POW + QL * i].pb;
	end

	for (genvar g = 0; g < NMUL; g++) begin : g_mul
		pkp_qmul u_qmul (
			.clk (clk),
			.en  (en),
			.a   (ma[g]),
			.b   (mb[g]),
			.p   (mres[g])
		);
	end

	// Stage logic: each stage passes the item on and updates its own fields
	always_comb begin
		logic signed [49:0] den;
		logic [47:0]        un;
		logic [63:0]        qr;
		q_t                 xr, yr;

		nx[0]      = '0;
		nx[0].x    = s_axis_tdata[47:0];
		nx[0].xp   = s_axis_tdata[95:48];
		nx[0].y    = s_axis_tdata[143:96];
		nx[0].yp   = s_axis_tdata[191:144];
		nx[0].s    = s_axis_tdata[239:192];
		nx[0].d    = s_axis_tdata[287:240];
		nx[0].last = s_axis_tlast;

		den = '0;
		un  = '0;
		qr  = '0;
		xr  = '0;
		yr  = '0;

		for (int k = 1; k < NST; k++) begin
			nx[k] = cr_s[k-1];

			// Divider setup for kick_strength / (1 + delta)
			if (k == DV_INIT) begin
				den = ext(ONE_Q) + ext(cr_s[k-1].d);
				un  = mag_q(kick_q);
				nx[k].dv_ud   = den[49] ? 48'(-den) : den[47:0];
				nx[k].dv_over = {16'b0, un} >= {1'b0, nx[k].dv_ud, 15'b0};
				nx[k].dv_rem  = 48'(un[47:15]);
				nx[k].dv_bits = {un[14:0], 32'b0};
				nx[k].dv_q    = '0;
				nx[k].dv_neg  = kick_q[QW-1] ^ den[49];
				nx[k].dv_zero = (kick_q == '0);
			end
			if (k > DV_INIT && k <= DV_LAST)
				nx[k] = dv_step(nx[k]);
			// Round the quotient and saturate
			if (k == DV_FIN) begin
				qr = 64'(cr_s[k-1].dv_q)
					+ 64'({cr_s[k-1].dv_rem, 1'b0} >= {1'b0, cr_s[k-1].dv_ud});
				if (cr_s[k-1].dv_zero)
					nx[k].kl = '0;
				else if (cr_s[k-1].dv_over)
					nx[k].kl = cr_s[k-1].dv_neg ? MIN_Q : MAX_Q;
				else
					nx[k].kl = sign_sat(qr, cr_s[k-1].dv_neg);
			end

			// Shift into the element frame, rotate slopes, start path term
			if (k == K_ROT) begin
				nx[k].x1  = sat_q(ext(cr_s[k-1].x) - ext(offx_q) + ext(mres[M_DZX]));
				nx[k].y1  = sat_q(ext(cr_s[k-1].y) - ext(offy_q) + ext(mres[M_DZY]));
				nx[k].xpr = sat_q(ext(mres[M_CXP]) + ext(mres[M_SYP]));
				nx[k].ypr = sat_q(ext(mres[M_CYP]) - ext(mres[M_SXP]));
				nx[k] = sq_init(nx[k], mres[M_SQX0], mres[M_SQY0]);
			end
			if ((k > SQ1_INIT && k <= K_PT1) || (k > SQ2_INIT && k <= K_PT2))
				nx[k] = sq_step(nx[k]);
			if (k == K_S1)
				nx[k].s1 = sat_q(ext(cr_s[k-1].s) + ext(mres[M_DZP1]));

			// Rotated positions and loss check
			if (k == K_POW) begin
				xr = sat_q(ext(mres[M_CX1]) + ext(mres[M_SY1]));
				yr = sat_q(ext(mres[M_CY1]) - ext(mres[M_SX1]));
				nx[k].xr   = xr;
				nx[k].yr   = yr;
				nx[k].pb   = plane_q ? yr : xr;
				nx[k].pw   = ONE_Q;
				nx[k].lost = (xr > COORD_LIMIT) || (xr < -COORD_LIMIT)
					|| (yr > COORD_LIMIT) || (yr < -COORD_LIMIT)
					|| (cr_s[k-1].xpr > SLOPE_LIMIT) || (cr_s[k-1].xpr < -SLOPE_LIMIT)
					|| (cr_s[k-1].ypr > SLOPE_LIMIT) || (cr_s[k-1].ypr < -SLOPE_LIMIT);
			end
			for (int i = 1; i <= POW_STEPS; i++) begin
				if (k == K_POW + QL * i + 1)
					nx[k].pw = pwv[i];
			end

			// Add the kick to the chosen slope
			if (k == K_BACK) begin
				if (plane_q)
					nx[k].ypr = sat_q(ext(cr_s[k-1].ypr) + ext(mres[M_KICK]));
				else
					nx[k].xpr = sat_q(ext(cr_s[k-1].xpr) + ext(mres[M_KICK]));
			end

			// Undo the rotation
			if (k == K_OUT) begin
				nx[k].xpo = sat_q(ext(mres[M_BCX]) - ext(mres[M_BSY]));
				nx[k].ypo = sat_q(ext(mres[M_BSX]) + ext(mres[M_BCY]));
			end

			// Undo the offsets and start the exit path term
			if (k == SQ2_INIT) begin
				nx[k].xo = sat_q(ext(cr_s[k-1].x1) + ext(offx_q) - ext(mres[M_DXO]));
				nx[k].yo = sat_q(ext(cr_s[k-1].y1) + ext(offy_q) - ext(mres[M_DYO]));
				nx[k] = sq_init(nx[k], mres[M_SQX1], mres[M_SQY1]);
			end

			// Final path coordinate; lost particles leave in the offset frame
			if (k == K_FIN) begin
				nx[k].so = sat_q(ext(cr_s[k-1].s1) - ext(mres[M_DZP2]));
				if (cr_s[k-1].lost) begin
					nx[k].xo  = cr_s[k-1].x1;
					nx[k].xpo = cr_s[k-1].xp;
					nx[k].yo  = cr_s[k-1].y1;
					nx[k].ypo = cr_s[k-1].yp;
					nx[k].so  = cr_s[k-1].s;
				end
			end
		end
	end

	// Advance the whole pipeline unless a result waits at the output
	assign en = !vld_s[NST-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NST-2:0], s_axis_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++)
				cr_s[k] <= nx[k];
		end
	end

	assign m_axis_tvalid = vld_s[NST-1];
	assign m_axis_tdata  = {cr_s[NST-1].d, cr_s[NST-1].so, cr_s[NST-1].ypo,
		cr_s[NST-1].yo, cr_s[NST-1].xpo, cr_s[NST-1].xo};
	assign m_axis_tuser  = cr_s[NST-1].lost;
	assign m_axis_tlast  = cr_s[NST-1].last;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DV_LAST] && !cr_s[DV_LAST].dv_over
		|-> cr_s[DV_LAST].dv_rem < cr_s[DV_LAST].dv_ud)
		else $error("divider remainder not below divisor");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[K_PT1] |-> cr_s[K_PT1].sq_rem <= 46'({cr_s[K_PT1].sq_root, 1'b0}))
		else $error("square root remainder out of range");

	a_lost_s: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] && cr_s[NST-1].lost |-> cr_s[NST-1].so == cr_s[NST-1].s)
		else $error("lost particle path coordinate changed");
`endif

endmodule
